// File: rtl/core/tpeq_pkg.sv
`timescale 1ns / 1ps

package tpeq_pkg;

	// Ring and pin table sizes.
	localparam int RING_DEPTH = 32;
	localparam int PIN_COUNT  = 64;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// Operation codes.
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic        op;
		logic [5:0]  pin;
		logic [63:0] edge_time;
		logic        edge_level;
		logic [31:0] edge_generation;
		logic [63:0] until_time;
	} in_item_t;

	typedef struct packed {
		logic        has_edge;
		logic [5:0]  out_pin;
		logic        out_level;
		logic [63:0] out_time;
		logic [5:0]  drained_total;
		logic [31:0] overflow_total;
		logic        last;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PG,
		ST_CANCEL,
		ST_STORE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cancel_step;
		logic store;
		logic drain_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_drain;
		logic pin_ok;
		logic need_cancel;
		logic walk_done;
		logic drain_stall;
		logic out_busy;
	} sts_t;

	// Ring position of head plus offset, wrapped once.
	function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] s);
		logic [CNT_W:0] r;
		r = (s >= (CNT_W+1)'(RING_DEPTH)) ? s - (CNT_W+1)'(RING_DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

endpackage

// File: rtl/core/tpeq_if.sv
`timescale 1ns / 1ps

interface tpeq_in_if;
	import tpeq_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tpeq_out_if;
	import tpeq_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/tpeq_ctrl.sv
`timescale 1ns / 1ps

module tpeq_ctrl
	import tpeq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PG;
				end
			end
			ST_PG: begin
				// The captured item and the pin generation read are now at hand.
				if (sts.is_drain) begin
					state_d = ST_DRAIN;
				end else if (!sts.pin_ok) begin
					state_d = ST_IDLE;
				end else if (sts.need_cancel) begin
					state_d = ST_CANCEL;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_CANCEL: begin
				if (sts.walk_done) begin
					state_d = ST_STORE;
				end else begin
					cmd.cancel_step = 1'b1;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_DRAIN: begin
				if (sts.walk_done) begin
					state_d = ST_FINISH;
				end else if (!sts.drain_stall) begin
					cmd.drain_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/tpeq_dp.sv
`timescale 1ns / 1ps

module tpeq_dp
	import tpeq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output sts_t      sts,
	input  logic      out_ready,
	output logic      out_valid,
	output res_item_t out_data
);

	// Ring storage.
	logic [63:0]      slot_time_q  [RING_DEPTH];
	logic [5:0]       slot_pin_q   [RING_DEPTH];
	logic             slot_lvl_q   [RING_DEPTH];
	logic [31:0]      slot_gen_q   [RING_DEPTH];
	logic             slot_valid_q [RING_DEPTH];

	// Per-pin generation memory with a valid bit per pin.
	logic [31:0]          pg_mem [PIN_COUNT];
	logic [31:0]          pg_rd_q;
	logic [PIN_COUNT-1:0] pg_vld_q;

	in_item_t         in_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [5:0]       drained_q;
	logic [31:0]      dropped_q;
	logic             pend_valid_q;
	logic [5:0]       pend_pin_q;
	logic             pend_lvl_q;
	logic [63:0]      pend_time_q;
	logic             out_valid_q;
	res_item_t        out_q;

	logic [IDX_W-1:0] k;
	logic [IDX_W-1:0] tail;
	logic [IDX_W-1:0] head_next;
	logic [31:0]      old_gen;
	logic             full;
	logic             sv;
	logic             due;
	logic             hit;
	logic             cancel_hit;
	logic             pin_ok;

	// Walk position, tail and status.
	always_comb begin
		k          = ring_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(idx_q));
		head_next  = ring_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
		full       = (cnt_q == CNT_W'(RING_DEPTH));
		tail       = full ? head_q : ring_wrap((CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q));
		old_gen    = pg_vld_q[in_q.pin] ? pg_rd_q : 32'd0;
		pin_ok     = ({1'b0, in_q.pin} < 7'(PIN_COUNT));
		sv         = slot_valid_q[k];
		due        = (slot_time_q[k] <= in_q.until_time);
		hit        = sv && due;
		cancel_hit = sv && (slot_pin_q[k] == in_q.pin) && (slot_gen_q[k] <= old_gen);

		sts.is_drain    = (in_q.op == OP_DRAIN);
		sts.pin_ok      = pin_ok;
		sts.need_cancel = (in_q.edge_generation != 32'd0) && (in_q.edge_generation != old_gen);
		sts.walk_done   = (idx_q >= cnt_q);
		sts.out_busy    = out_valid_q && !out_ready;
		sts.drain_stall = hit && pend_valid_q && sts.out_busy;
	end

	// Slot arrays: written on store, invalidated by cancel and drain.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			slot_time_q[tail]  <= in_q.edge_time;
			slot_pin_q[tail]   <= in_q.pin;
			slot_lvl_q[tail]   <= in_q.edge_level;
			slot_gen_q[tail]   <= in_q.edge_generation;
			slot_valid_q[tail] <= 1'b1;
		end
		if (cmd.cancel_step && cancel_hit) begin
			slot_valid_q[k] <= 1'b0;
		end
		if (cmd.drain_step && hit) begin
			slot_valid_q[k] <= 1'b0;
		end
	end

	// Pin generation memory, registered read at capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pg_rd_q <= pg_mem[in_data.pin];
		end
		if (cmd.store && sts.need_cancel) begin
			pg_mem[in_q.pin] <= in_q.edge_generation;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.drain_step && hit) begin
			pend_pin_q  <= slot_pin_q[k];
			pend_lvl_q  <= slot_lvl_q[k];
			pend_time_q <= slot_time_q[k];
		end
		if (cmd.drain_step && hit && pend_valid_q) begin
			out_q.has_edge       <= 1'b1;
			out_q.out_pin        <= pend_pin_q;
			out_q.out_level      <= pend_lvl_q;
			out_q.out_time       <= pend_time_q;
			out_q.drained_total  <= 6'd0;
			out_q.overflow_total <= dropped_q;
			out_q.last           <= 1'b0;
		end
		if (cmd.finish) begin
			out_q.has_edge       <= pend_valid_q;
			out_q.out_pin        <= pend_valid_q ? pend_pin_q : 6'd0;
			out_q.out_level      <= pend_valid_q && pend_lvl_q;
			out_q.out_time       <= pend_valid_q ? pend_time_q : 64'd0;
			out_q.drained_total  <= drained_q;
			out_q.overflow_total <= dropped_q;
			out_q.last           <= 1'b1;
		end
	end

	// Control registers: ring pointers, counters, pending, output valid and pin valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			drained_q    <= '0;
			dropped_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			pg_vld_q     <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.capture) begin
				idx_q        <= '0;
				drained_q    <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.cancel_step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.store) begin
				if (full) begin
					dropped_q <= dropped_q + 32'd1;
					head_q    <= head_next;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (sts.need_cancel) begin
					pg_vld_q[in_q.pin] <= 1'b1;
				end
			end
			if (cmd.drain_step) begin
				// Dead or emitted entries at the head leave the ring.
				if ((!sv || hit) && idx_q == '0) begin
					head_q <= head_next;
					cnt_q  <= cnt_q - CNT_W'(1);
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					drained_q    <= drained_q + 6'd1;
					pend_valid_q <= 1'b1;
					if (pend_valid_q) begin
						out_valid_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/timed_pin_edge_queue.sv
`timescale 1ns / 1ps

// Ring queue of timed pin edges with one input channel and one result channel.
// A push reads the pin generation, runs the cancel walk over the queued entries
// when a new generation for the pin asks for it, then stores; it yields no item.
// A drain walks the ring entries, at most the ring depth, and waits while the
// result channel stalls; it yields one item per emitted edge, or a single empty
// item, the final one marked last with the count. The ring is walked one slot
// per cycle, save while a drain waits on a stalled result channel. One item is
// worked on at a time; finished results wait in an output register.

module timed_pin_edge_queue
	import tpeq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tpeq_in_if.sink    in_ch,
	tpeq_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	tpeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Ring, generation table and output register.
	tpeq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_data  (out_ch.data)
	);

endmodule

// File: rtl/core/tpeq_checker.sv
`timescale 1ns / 1ps

module tpeq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_op,
	input logic out_valid,
	input logic out_ready,
	input logic out_has_edge,
	input logic out_last,
	input logic [5:0] out_drained_total
);

	// The block works on one item at a time after accepting it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after an accepted item");

	// An item without an edge is always the single, final item of a drain.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has_edge |-> out_last && out_drained_total == 6'd0)
		else $error("empty result not marked last or carries a count");

	// Only the final item carries a count.
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_drained_total == 6'd0)
		else $error("count on a non-final result");

	// A push never produces a result in the following cycle.
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_op && !(out_valid && !out_ready) |=> !out_valid)
		else $error("result appeared after a push");

endmodule

bind timed_pin_edge_queue tpeq_checker u_tpeq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.in_op             (in_ch.data.op),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_has_edge      (out_ch.data.has_edge),
	.out_last          (out_ch.data.last),
	.out_drained_total (out_ch.data.drained_total)
);

// File: bench/tb_timed_pin_edge_queue.sv
`timescale 1ns / 1ps

module tb_timed_pin_edge_queue;
	import tpeq_pkg::*;

	logic clk;
	logic arst_n;

	tpeq_in_if  in_ch ();
	tpeq_out_if out_ch ();

	timed_pin_edge_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Predictor state: one copy of the ring and the pin table.
	logic [63:0] ring_time [RING_DEPTH];
	logic        ring_valid [RING_DEPTH];
	logic [31:0] ring_gen [RING_DEPTH];
	logic        ring_level [RING_DEPTH];
	logic [5:0]  ring_pin [RING_DEPTH];
	int unsigned ring_head;
	int unsigned ring_fill;
	logic [31:0] drop_count;
	logic [31:0] pin_gen [PIN_COUNT];

	res_item_t   expected_edges [$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	localparam int unsigned CYCLE_LIMIT = 400000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic int unsigned ring_at(input int unsigned offset);
		return (ring_head + offset) % RING_DEPTH;
	endfunction

	// Works out the results of one accepted item and queues them.
	task automatic predict_edges(input in_item_t it);
		int unsigned i;
		int unsigned k;
		int unsigned drained;
		res_item_t r;
		if (it.op == OP_PUSH) begin
			if (it.edge_generation != 0 && it.edge_generation != pin_gen[it.pin]) begin
				for (i = 0; i < ring_fill; i++) begin
					k = ring_at(i);
					if (ring_valid[k] && ring_pin[k] == it.pin
						&& ring_gen[k] <= pin_gen[it.pin])
						ring_valid[k] = 1'b0;
				end
				pin_gen[it.pin] = it.edge_generation;
			end
			if (ring_fill >= RING_DEPTH) begin
				drop_count++;
				ring_head = ring_at(1);
				ring_fill--;
			end
			k = ring_at(ring_fill);
			ring_time[k]  = it.edge_time;
			ring_pin[k]   = it.pin;
			ring_level[k] = it.edge_level;
			ring_gen[k]   = it.edge_generation;
			ring_valid[k] = 1'b1;
			ring_fill++;
		end else begin
			drained = 0;
			i = 0;
			while (i < ring_fill) begin
				k = ring_at(i);
				if (ring_valid[k] && ring_time[k] <= it.until_time) begin
					ring_valid[k] = 1'b0;
					r = '0;
					r.has_edge = 1'b1;
					r.out_pin = ring_pin[k];
					r.out_level = ring_level[k];
					r.out_time = ring_time[k];
					r.overflow_total = drop_count;
					expected_edges.push_back(r);
					drained++;
					if (i == 0) begin
						ring_head = ring_at(1);
						ring_fill--;
					end else begin
						i++;
					end
				end else if (!ring_valid[k] && i == 0) begin
					ring_head = ring_at(1);
					ring_fill--;
				end else begin
					i++;
				end
			end
			if (drained == 0) begin
				r = '0;
				r.overflow_total = drop_count;
				r.last = 1'b1;
				expected_edges.push_back(r);
			end else begin
				r = expected_edges.pop_back();
				r.drained_total = 6'(drained);
				r.last = 1'b1;
				expected_edges.push_back(r);
			end
		end
	endtask

	// Sends one item, with random idle cycles before it. The block is busy after
	// an accepted item, so valid drops once the item is taken.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_edges(it);
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_edge(input logic [5:0] p, input logic [63:0] t,
		input logic lvl, input logic [31:0] g);
		in_item_t it;
		it = '0;
		it.op = OP_PUSH;
		it.pin = p;
		it.edge_time = t;
		it.edge_level = lvl;
		it.edge_generation = g;
		it.until_time = {$urandom, $urandom};
		send_item(it);
	endtask

	task automatic drain_until(input logic [63:0] limit);
		in_item_t it;
		it = '0;
		it.op = OP_DRAIN;
		it.pin = 6'($urandom);
		it.edge_time = {$urandom, $urandom};
		it.edge_level = 1'($urandom);
		it.edge_generation = $urandom;
		it.until_time = limit;
		send_item(it);
	endtask

	task automatic wait_all_results();
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Receiver side: random stalls and the result check.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_edges.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_edges.pop_front();
				if (out_ch.data.has_edge !== want.has_edge)
					report_mismatch($sformatf("has_edge %0b want %0b",
						out_ch.data.has_edge, want.has_edge));
				if (out_ch.data.out_pin !== want.out_pin)
					report_mismatch($sformatf("out_pin %0d want %0d",
						out_ch.data.out_pin, want.out_pin));
				if (out_ch.data.out_level !== want.out_level)
					report_mismatch("out_level differs");
				if (out_ch.data.out_time !== want.out_time)
					report_mismatch($sformatf("out_time %0h want %0h",
						out_ch.data.out_time, want.out_time));
				if (out_ch.data.drained_total !== want.drained_total)
					report_mismatch($sformatf("drained_total %0d want %0d",
						out_ch.data.drained_total, want.drained_total));
				if (out_ch.data.overflow_total !== want.overflow_total)
					report_mismatch($sformatf("overflow_total %0d want %0d",
						out_ch.data.overflow_total, want.overflow_total));
				if (out_ch.data.last !== want.last)
					report_mismatch("last differs");
			end
		end
	end

	// Extremes of time and pin, empty drains, and the untagged case.
	task automatic test_directed();
		drain_until(64'hFFFF_FFFF_FFFF_FFFF);
		push_edge(6'd0, 64'd0, 1'b0, 32'd0);
		push_edge(6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		push_edge(6'd5, 64'd100, 1'b1, 32'd0);
		drain_until(64'd0);
		drain_until(64'd99);
		drain_until(64'hFFFF_FFFF_FFFF_FFFE);
		drain_until(64'hFFFF_FFFF_FFFF_FFFF);
		drain_until(64'd0);
	endtask

	// A new generation cancels older edges of the pin, middle and head alike.
	task automatic test_generation_cancel();
		push_edge(6'd3, 64'd50, 1'b1, 32'd1);
		push_edge(6'd4, 64'd10, 1'b0, 32'd0);
		push_edge(6'd3, 64'd60, 1'b0, 32'd1);
		push_edge(6'd3, 64'd70, 1'b1, 32'd2);
		push_edge(6'd3, 64'd80, 1'b0, 32'd0);
		drain_until(64'd75);
		drain_until(64'd200);
	endtask

	// Over-filling the ring drops the oldest entries.
	task automatic test_overflow();
		int i;
		for (i = 0; i < RING_DEPTH + 5; i++)
			push_edge(6'($urandom), 64'(i), 1'($urandom), 32'd0);
		drain_until(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Random pushes with some drains, on a few pins so cancels happen.
	task automatic test_random(input int n);
		int i;
		logic [63:0] t;
		logic [31:0] g;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 22) begin
				case ($urandom_range(3))
					0: drain_until({$urandom, $urandom});
					default: drain_until(64'($urandom_range(1200)));
				endcase
			end else begin
				t = ($urandom_range(9) == 0) ? {$urandom, $urandom}
					: 64'($urandom_range(1000));
				case ($urandom_range(3))
					0: g = 32'd0;
					1: g = $urandom;
					default: g = 32'($urandom_range(4));
				endcase
				push_edge(($urandom_range(1) == 0) ? 6'($urandom_range(3)) : 6'($urandom),
					t, 1'($urandom), g);
			end
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		error_count = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		send_idle_pct = 26;
		recv_idle_pct = 80;
		ring_head = 0;
		ring_fill = 0;
		drop_count = '0;
		for (i = 0; i < RING_DEPTH; i++) ring_valid[i] = 1'b0;
		for (i = 0; i < PIN_COUNT; i++) pin_gen[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_generation_cancel();
		test_overflow();
		test_random(80);
		wait_all_results();

		send_idle_pct = 80;
		recv_idle_pct = 26;
		test_random(90);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(90);

		wait_all_results();
		if (error_count == 0 && expected_edges.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: timed_pin_edge_queue.f
rtl/core/tpeq_pkg.sv
rtl/core/tpeq_if.sv
rtl/core/tpeq_ctrl.sv
rtl/core/tpeq_dp.sv
rtl/core/timed_pin_edge_queue.sv
rtl/core/tpeq_checker.sv
bench/tb_timed_pin_edge_queue.sv
